// ===== sv/oscgm_pkg.sv =====
// ----------------------------------------------------------------------------
// oscgm_pkg
// Types, constants and saturating Q16.16 helpers for the oscillator
// Gaussian moment block.
// ----------------------------------------------------------------------------
`default_nettype none

package oscgm_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NSTG      = 11;

  typedef logic signed [DATA_W-1:0]   word_t;
  typedef logic signed [DATA_W+1:0]   wide_t;
  typedef logic signed [2*DATA_W-1:0] prod_t;
  typedef logic [2*DATA_W-1:0]        uprod_t;
  typedef logic [DATA_W-2:0]          uword_t;

  localparam word_t  MAXV          = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t  MINV          = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t  ONE           = word_t'(uprod_t'(1) << FRAC_W);
  localparam uword_t TIME_STEP_RST = uword_t'(6554);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OMEGA,
    REG_ALPHA,
    REG_BETA,
    REG_TIME_STEP,
    REG_OBS_NOISE_A,
    REG_OBS_NOISE_B,
    REG_DRIVE_NOISE
  } cfg_reg_t;

  typedef struct packed {
    word_t pred_mean_0;
    word_t pred_mean_1;
    word_t pred_cov_00;
    word_t pred_cov_01;
    word_t pred_cov_11;
    word_t obs_mean_0;
    word_t obs_mean_1;
    word_t obs_cov_00;
    word_t obs_cov_01;
    word_t obs_cov_11;
  } res_t;

  function automatic word_t f_clamp(wide_t v);
    word_t r;
    if (v > wide_t'(MAXV)) begin
      r = MAXV;
    end else if (v < wide_t'(MINV)) begin
      r = MINV;
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  function automatic word_t f_add(word_t a, word_t b);
    return f_clamp(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t f_sub(word_t a, word_t b);
    return f_clamp(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic word_t f_neg(word_t a);
    return f_clamp(-wide_t'(a));
  endfunction

  function automatic word_t f_dbl(word_t a);
    return f_clamp(wide_t'(a) + wide_t'(a));
  endfunction

  function automatic word_t f_tpl(word_t a);
    return f_clamp(wide_t'(a) + wide_t'(a) + wide_t'(a));
  endfunction

  // exact product, round half away from zero, saturate
  function automatic word_t f_mul(word_t a, word_t b);
    prod_t  p;
    uprod_t mag;
    uprod_t rnd;
    uprod_t lim;
    logic   sgn;
    p   = prod_t'(a) * prod_t'(b);
    sgn = a[DATA_W-1] ^ b[DATA_W-1];
    mag = p[2*DATA_W-1] ? uprod_t'(-p) : uprod_t'(p);
    rnd = (mag + (uprod_t'(1) << (FRAC_W-1))) >> FRAC_W;
    lim = sgn ? (uprod_t'(1) << (DATA_W-1)) : uprod_t'(MAXV);
    if (rnd > lim) begin
      rnd = lim;
    end
    return sgn ? word_t'(-rnd) : word_t'(rnd);
  endfunction

endpackage

`default_nettype wire

// ===== sv/oscillator_gaussian_moment_terms_top.sv =====
// ----------------------------------------------------------------------------
// oscillator_gaussian_moment_terms_top
// Raw Gaussian moments and predicted / observation mean and covariance of a
// damped nonlinear oscillator step, saturating Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   An item (mean and 2x2 covariance) is taken at a clock edge with start
//   high and busy low. busy is high only during reset, so one item can be
//   taken every cycle.
//   Each item's ten results appear on the output ports for one cycle with
//   done high. Items come out in order. The receiver has no stall; results
//   must be taken as shown.
//   The pipeline depth is set by the longest chain of rounded products (the
//   a42 moment followed by three scalings), one product level per stage
//   across an 11-register pipeline.
//   Configuration: cfg_we, cfg_index, cfg_data write one register per edge.
//   Write only while no item is in flight; derived coefficient terms pass
//   through the k1 to k5 registers and settle before any later item needs them.
//   Reset (rst, synchronous) restores the register defaults and empties
//   the pipeline; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module oscillator_gaussian_moment_terms_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  oscgm_pkg::word_t                      mean_x0,
  input  oscgm_pkg::word_t                      mean_x1,
  input  oscgm_pkg::uword_t                     cov_00,
  input  oscgm_pkg::word_t                      cov_01,
  input  oscgm_pkg::word_t                      cov_10,
  input  oscgm_pkg::uword_t                     cov_11,
  input  logic                                  cfg_we,
  input  logic [oscgm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  oscgm_pkg::word_t                      cfg_data,
  output logic                                  done,
  output oscgm_pkg::word_t                      pred_mean_0,
  output oscgm_pkg::word_t                      pred_mean_1,
  output oscgm_pkg::word_t                      pred_cov_00,
  output oscgm_pkg::word_t                      pred_cov_01,
  output oscgm_pkg::word_t                      pred_cov_11,
  output oscgm_pkg::word_t                      obs_mean_0,
  output oscgm_pkg::word_t                      obs_mean_1,
  output oscgm_pkg::word_t                      obs_cov_00,
  output oscgm_pkg::word_t                      obs_cov_01,
  output oscgm_pkg::word_t                      obs_cov_11
);
  import oscgm_pkg::*;

  // configuration
  word_t  omega, alpha, beta, wa, wb, mv;
  uword_t time_step;
  word_t  dt;

  // derived coefficient pipeline (depth in name)
  word_t k1_w2, k1_dt2, k1_al2, k1_be2, k1_dtal, k1_albe;
  word_t k1_wawa, k1_wawb, k1_wbwb, k1_dtx2;
  word_t k2_nw2, k2_w4, k2_dtal1, k2_x1, k2_dtw2, k2_c5, k2_dt2x2;
  word_t k3_x2, k3_c4, k3_c3a;
  word_t k4_c3b;
  word_t k5_c3;

  logic [NSTG-1:0] vld;
  res_t            rs [1:10];
  res_t            rs_next [1:10];
  logic            cfg_chg;

  word_t s0_m0, s0_m1, s0_c00, s0_c01, s0_c10, s0_c11;
  word_t s1_m0, s1_m1, s1_c00, s1_c01, s1_c10, s1_c11, s1_a20, s1_a11, s1_a02;
  word_t s1_t21a, s1_t21b, s1_t12c, s1_t30, s1_pmv, s1_pwa, s1_pwb2;
  word_t s2_m0, s2_m1, s2_c00, s2_c01, s2_c10, s2_a20, s2_a11, s2_a21, s2_a12;
  word_t s2_a30, s2_u31a, s2_u31b, s2_u22c, s2_u40, s2_ta, s2_x00, s2_tt00;
  word_t s2_pmv, s2_p11, s2_p01, s2_p00m, s2_v01c, s2_v01b, s2_v11d, s2_v11e;
  word_t s3_m0, s3_m1, s3_c00, s3_c01, s3_a22, s3_a31, s3_w32b, s3_w32c, s3_tb;
  word_t s3_pmv, s3_hh0, s3_hh01, s3_hh11, s3_p00, s3_p01, s3_p11;
  word_t s3_v01b, s3_v01c2, s3_v01e, s3_v11c, s3_v11d, s3_v11e2;
  word_t s4_m0, s4_a32, s4_y42b, s4_y42c, s4_z1, s4_z2, s4_z3, s4_a31;
  word_t s4_v01b, s4_v01c2, s4_v01e, s4_v11c, s4_v11d, s4_v11e3;
  word_t s5_a42, s5_z1b, s5_z2b, s5_z3b, s5_v11f, s5_tt01, s5_tt11;
  word_t s5_v01b, s5_v01c2, s5_v01e, s5_v11c, s5_v11d, s5_v11e3;
  word_t s6_z1c, s6_z2c, s6_z3c, s6_q1, s6_tt01, s6_tt11;
  word_t s6_v01b, s6_v01c2, s6_v01e, s6_v11c, s6_v11d, s6_v11e3, s6_v11f;
  word_t s7_x01, s7_z3d, s7_q2, s7_tt01, s7_tt11;
  word_t s7_v11c, s7_v11d, s7_v11e3, s7_v11f;
  word_t s8_q3, s8_z3d, s8_tt11, s8_v11c, s8_v11d, s8_v11e3, s8_v11f;
  word_t s9_x11t, s9_v11d, s9_v11e3, s9_tt11;

  assign busy    = rst;
  assign dt      = word_t'(time_step);
  assign cfg_chg = cfg_we || rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega     <= ONE;
      alpha     <= ONE;
      beta      <= ONE;
      time_step <= TIME_STEP_RST;
      wa        <= '0;
      wb        <= '0;
      mv        <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OMEGA:       omega     <= cfg_data;
        REG_ALPHA:       alpha     <= cfg_data;
        REG_BETA:        beta      <= cfg_data;
        REG_TIME_STEP:   time_step <= cfg_data[DATA_W-2:0];
        REG_OBS_NOISE_A: wa        <= cfg_data;
        REG_OBS_NOISE_B: wb        <= cfg_data;
        REG_DRIVE_NOISE: mv        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    k1_w2    <= f_mul(omega, omega);
    k1_dt2   <= f_mul(dt, dt);
    k1_al2   <= f_mul(alpha, alpha);
    k1_be2   <= f_mul(beta, beta);
    k1_dtal  <= f_mul(dt, alpha);
    k1_albe  <= f_mul(alpha, beta);
    k1_wawa  <= f_mul(wa, wa);
    k1_wawb  <= f_mul(wa, wb);
    k1_wbwb  <= f_mul(wb, wb);
    k1_dtx2  <= f_dbl(dt);
    k2_nw2   <= f_neg(k1_w2);
    k2_w4    <= f_mul(k1_w2, k1_w2);
    k2_dtal1 <= f_add(k1_dtal, ONE);
    k2_x1    <= f_add(f_mul(alpha, k1_dt2), dt);
    k2_dtw2  <= f_mul(k1_dt2, k1_w2);
    k2_c5    <= f_add(f_add(f_mul(k1_dt2, k1_al2), f_mul(k1_dtx2, alpha)), ONE);
    k2_dt2x2 <= f_dbl(k1_dt2);
    k3_x2    <= f_add(f_sub(k1_dtal, k2_dtw2), ONE);
    k3_c4    <= f_add(f_mul(k1_dt2, k2_w4), dt);
    k3_c3a   <= f_mul(k2_dt2x2, k1_w2);
    k4_c3b   <= f_mul(k3_c3a, alpha);
    k5_c3    <= f_mul(k4_c3b, beta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTG-2:0], start && !busy};
    end
  end

  // result fields travel with the item; each stage fills in what it finishes
  always_comb begin
    rs_next[1]                = '0;
    rs_next[1].pred_mean_0    = f_add(s0_m0, f_mul(dt, s0_m1));
    rs_next[1].obs_mean_1     = f_add(s0_m1, wb);
    rs_next[2]                = rs[1];
    rs_next[2].obs_mean_0     = f_add(s1_a20, wa);
    rs_next[3]                = rs[2];
    rs_next[3].pred_cov_00    = f_sub(s2_x00, s2_tt00);
    rs_next[4]                = rs[3];
    rs_next[4].pred_mean_1    = f_add(f_add(s3_m1, f_mul(dt, s3_tb)), s3_pmv);
    rs_next[4].obs_cov_00     = f_sub(s3_p00, s3_hh0);
    rs_next[4].obs_cov_01     = f_sub(s3_p01, s3_hh01);
    rs_next[4].obs_cov_11     = f_sub(s3_p11, s3_hh11);
    rs_next[5]                = rs[4];
    rs_next[6]                = rs[5];
    rs_next[7]                = rs[6];
    rs_next[8]                = rs[7];
    rs_next[8].pred_cov_01    = f_sub(s7_x01, s7_tt01);
    rs_next[9]                = rs[8];
    rs_next[10]               = rs[9];
    rs_next[10].pred_cov_11   = f_sub(f_sub(f_add(s9_x11t, s9_v11d), s9_v11e3), s9_tt11);
  end

  always_ff @(posedge clk) begin
    rs <= rs_next;
  end

  always_ff @(posedge clk) begin
    // stage 0: capture
    s0_m0  <= mean_x0;
    s0_m1  <= mean_x1;
    s0_c00 <= word_t'(cov_00);
    s0_c01 <= cov_01;
    s0_c10 <= cov_10;
    s0_c11 <= word_t'(cov_11);

    // stage 1: second order moments
    s1_m0   <= s0_m0;
    s1_m1   <= s0_m1;
    s1_c00  <= s0_c00;
    s1_c01  <= s0_c01;
    s1_c10  <= s0_c10;
    s1_c11  <= s0_c11;
    s1_a20  <= f_add(f_mul(s0_m0, s0_m0), s0_c00);
    s1_a11  <= f_add(f_mul(s0_m1, s0_m0), f_mul(s0_c10, s0_m1));
    s1_a02  <= f_add(f_mul(s0_m1, s0_m1), s0_c11);
    s1_t21a <= f_mul(s0_c00, s0_m1);
    s1_t21b <= f_mul(s0_c01, s0_m0);
    s1_t12c <= f_mul(s0_c11, s0_m0);
    s1_t30  <= f_mul(f_dbl(s0_c00), s0_m0);
    s1_pmv  <= f_mul(s0_m0, mv);
    s1_pwa  <= f_mul(s0_m1, wa);
    s1_pwb2 <= f_mul(f_dbl(s0_m1), wb);

    // stage 2: third order moments
    s2_m0   <= s1_m0;
    s2_m1   <= s1_m1;
    s2_c00  <= s1_c00;
    s2_c01  <= s1_c01;
    s2_c10  <= s1_c10;
    s2_a20  <= s1_a20;
    s2_a11  <= s1_a11;
    s2_a21  <= f_add(f_add(f_mul(s1_m0, s1_a11), s1_t21a), s1_t21b);
    s2_a12  <= f_add(f_add(f_mul(s1_m1, s1_a11), f_mul(s1_c10, s1_a02)), s1_t12c);
    s2_a30  <= f_add(f_mul(s1_m0, s1_a20), s1_t30);
    s2_u31a <= f_mul(f_dbl(s1_c00), s1_a11);
    s2_u31b <= f_mul(s1_c01, s1_a20);
    s2_u22c <= f_mul(s1_c11, s1_a20);
    s2_u40  <= f_mul(f_tpl(s1_c00), s1_a20);
    s2_ta   <= f_add(f_mul(k2_nw2, s1_m0), f_mul(alpha, s1_m1));
    s2_x00  <= f_add(f_add(s1_a20, f_mul(k1_dtx2, s1_a11)), f_mul(k1_dt2, s1_a02));
    s2_tt00 <= f_mul(rs[1].pred_mean_0, rs[1].pred_mean_0);
    s2_pmv  <= s1_pmv;
    s2_p11  <= f_add(f_add(s1_a02, s1_pwb2), k1_wbwb);
    s2_p01  <= f_add(f_add(f_add(s1_a11, f_mul(s1_a20, wb)), s1_pwa), k1_wawb);
    s2_p00m <= f_mul(f_dbl(s1_a20), k1_wawa);
    s2_v01c <= f_mul(s1_a20, dt);
    s2_v01b <= f_mul(s1_a02, k2_x1);
    s2_v11d <= f_mul(s1_a02, k2_c5);
    s2_v11e <= f_mul(f_dbl(s1_a11), dt);

    // stage 3: a22, a31, a40
    s3_m0    <= s2_m0;
    s3_m1    <= s2_m1;
    s3_c00   <= s2_c00;
    s3_c01   <= s2_c01;
    s3_a22   <= f_add(f_add(f_mul(s2_m1, s2_a21), f_mul(f_dbl(s2_c10), s2_a12)), s2_u22c);
    s3_a31   <= f_add(f_add(f_mul(s2_m0, s2_a21), s2_u31a), s2_u31b);
    s3_w32b  <= f_mul(f_dbl(s2_c00), s2_a12);
    s3_w32c  <= f_mul(f_dbl(s2_c01), s2_a21);
    s3_tb    <= f_sub(s2_ta, f_mul(k1_albe, s2_a21));
    s3_pmv   <= s2_pmv;
    s3_hh0   <= f_mul(rs[2].obs_mean_0, rs[2].obs_mean_0);
    s3_hh01  <= f_mul(rs[2].obs_mean_0, rs[2].obs_mean_1);
    s3_hh11  <= f_mul(rs[2].obs_mean_1, rs[2].obs_mean_1);
    s3_p00   <= f_add(f_add(f_mul(s2_m0, s2_a30), s2_u40), s2_p00m);
    s3_p01   <= s2_p01;
    s3_p11   <= s2_p11;
    s3_v01b  <= s2_v01b;
    s3_v01c2 <= f_mul(s2_v01c, k1_w2);
    s3_v01e  <= f_mul(s2_a11, k3_x2);
    s3_v11c  <= f_mul(s2_a20, k3_c4);
    s3_v11d  <= s2_v11d;
    s3_v11e2 <= f_mul(s2_v11e, k1_w2);

    // stage 4: a32, tau1, observation covariance
    s4_m0    <= s3_m0;
    s4_a32   <= f_add(f_add(f_mul(s3_m0, s3_a22), s3_w32b), s3_w32c);
    s4_y42b  <= f_mul(f_tpl(s3_c00), s3_a22);
    s4_y42c  <= f_mul(f_dbl(s3_c01), s3_a31);
    s4_z1    <= f_mul(f_neg(s3_a31), alpha);
    s4_z2    <= f_mul(s3_a22, alpha);
    s4_z3    <= f_mul(f_dbl(s3_a22), dt);
    s4_a31   <= s3_a31;
    s4_v01b  <= s3_v01b;
    s4_v01c2 <= s3_v01c2;
    s4_v01e  <= s3_v01e;
    s4_v11c  <= s3_v11c;
    s4_v11d  <= s3_v11d;
    s4_v11e3 <= f_mul(s3_v11e2, k2_dtal1);

    // stage 5: a42
    s5_a42   <= f_add(f_add(f_mul(s4_m0, s4_a32), s4_y42b), s4_y42c);
    s5_z1b   <= f_mul(s4_z1, beta);
    s5_z2b   <= f_mul(s4_z2, beta);
    s5_z3b   <= f_mul(s4_z3, alpha);
    s5_v11f  <= f_mul(s4_a31, k5_c3);
    s5_tt01  <= f_mul(rs[4].pred_mean_0, rs[4].pred_mean_1);
    s5_tt11  <= f_mul(rs[4].pred_mean_1, rs[4].pred_mean_1);
    s5_v01b  <= s4_v01b;
    s5_v01c2 <= s4_v01c2;
    s5_v01e  <= s4_v01e;
    s5_v11c  <= s4_v11c;
    s5_v11d  <= s4_v11d;
    s5_v11e3 <= s4_v11e3;

    // stage 6
    s6_z1c   <= f_mul(s5_z1b, dt);
    s6_z2c   <= f_mul(s5_z2b, k1_dt2);
    s6_z3c   <= f_mul(s5_z3b, beta);
    s6_q1    <= f_mul(s5_a42, k1_dt2);
    s6_tt01  <= s5_tt01;
    s6_tt11  <= s5_tt11;
    s6_v01b  <= s5_v01b;
    s6_v01c2 <= s5_v01c2;
    s6_v01e  <= s5_v01e;
    s6_v11c  <= s5_v11c;
    s6_v11d  <= s5_v11d;
    s6_v11e3 <= s5_v11e3;
    s6_v11f  <= s5_v11f;

    // stage 7: Xi 0,1
    s7_x01   <= f_add(f_sub(f_add(f_sub(s6_z1c, s6_z2c), s6_v01b), s6_v01c2), s6_v01e);
    s7_z3d   <= f_mul(s6_z3c, k2_dtal1);
    s7_q2    <= f_mul(s6_q1, k1_al2);
    s7_tt01  <= s6_tt01;
    s7_tt11  <= s6_tt11;
    s7_v11c  <= s6_v11c;
    s7_v11d  <= s6_v11d;
    s7_v11e3 <= s6_v11e3;
    s7_v11f  <= s6_v11f;

    // stage 8
    s8_q3    <= f_mul(s7_q2, k1_be2);
    s8_z3d   <= s7_z3d;
    s8_tt11  <= s7_tt11;
    s8_v11c  <= s7_v11c;
    s8_v11d  <= s7_v11d;
    s8_v11e3 <= s7_v11e3;
    s8_v11f  <= s7_v11f;

    // stage 9: Xi 1,1 first half
    s9_x11t  <= f_add(f_add(f_sub(s8_q3, s8_z3d), s8_v11f), s8_v11c);
    s9_v11d  <= s8_v11d;
    s9_v11e3 <= s8_v11e3;
    s9_tt11  <= s8_tt11;
  end

  assign done        = vld[NSTG-1];
  assign pred_mean_0 = rs[10].pred_mean_0;
  assign pred_mean_1 = rs[10].pred_mean_1;
  assign pred_cov_00 = rs[10].pred_cov_00;
  assign pred_cov_01 = rs[10].pred_cov_01;
  assign pred_cov_11 = rs[10].pred_cov_11;
  assign obs_mean_0  = rs[10].obs_mean_0;
  assign obs_mean_1  = rs[10].obs_mean_1;
  assign obs_cov_00  = rs[10].obs_cov_00;
  assign obs_cov_01  = rs[10].obs_cov_01;
  assign obs_cov_11  = rs[10].obs_cov_11;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##11 done)
    else $error("item did not complete after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 11))
    else $error("result without a matching item");

  a_coef_settled: assert property (@(posedge clk) disable iff (rst)
    (!cfg_chg && !$past(cfg_chg, 1) && !$past(cfg_chg, 2) && !$past(cfg_chg, 3)
      && !$past(cfg_chg, 4) && !$past(cfg_chg, 5) && !$past(cfg_chg, 6)
      && !$past(cfg_chg, 7)) |-> $stable(k5_c3))
    else $error("derived coefficient moved without a configuration write");

endmodule

`default_nettype wire
